FILE: src/cdut_pkg.sv
// cdut_pkg: word types, calendar constants and reciprocal multipliers
// shared by the civil date / unix time converter; depends on nothing
`timescale 1ns / 1ps

package cdut_pkg;

  typedef struct packed {
    logic        op;
    logic [37:0] in_unix_seconds;
    logic [13:0] in_year;
    logic [3:0]  in_month;
    logic [4:0]  in_day;
    logic [4:0]  in_hour;
    logic [5:0]  in_minute;
    logic [5:0]  in_second;
  } in_word_t;

  typedef struct packed {
    logic [37:0] out_unix_seconds;
    logic [13:0] out_year;
    logic [3:0]  out_month;
    logic [4:0]  out_day;
    logic [4:0]  out_hour;
    logic [5:0]  out_minute;
    logic [5:0]  out_second;
    logic [2:0]  weekday;
    logic        leap_flag;
    logic [4:0]  month_length;
    logic        range_error;
  } out_word_t;

  localparam logic        OP_TO_UNIX   = 1'b0;
  localparam logic        OP_FROM_UNIX = 1'b1;

  localparam logic [37:0] MAX_UNIX     = 38'd253402300799;
  localparam logic [21:0] EPOCH_SHIFT  = 22'd719468;
  localparam logic [16:0] SECS_PER_DAY = 17'd86400;

  localparam int FRONT_STAGES = 3;
  localparam int SPLIT_STAGES = 10;

  // exact reciprocals: m = ceil(2^k / d), k = value bits + ceil(log2 d)
  localparam logic [31:0] M675    = 32'(((64'd1 << 41) + 64'd674) / 64'd675);
  localparam logic [22:0] M146097 = 23'(((64'd1 << 40) + 64'd146096) / 64'd146097);
  localparam logic [22:0] M7      = 23'(((64'd1 << 25) + 64'd6) / 64'd7);
  localparam logic [17:0] M3600   = 18'(((64'd1 << 29) + 64'd3599) / 64'd3600);
  localparam logic [18:0] M1460   = 19'(((64'd1 << 29) + 64'd1459) / 64'd1460);
  localparam logic [18:0] M36524  = 19'(((64'd1 << 34) + 64'd36523) / 64'd36524);
  localparam logic [18:0] M146096 = 19'(((64'd1 << 36) + 64'd146095) / 64'd146096);
  localparam logic [18:0] M365    = 19'(((64'd1 << 27) + 64'd364) / 64'd365);
  localparam logic [12:0] M60     = 13'(((64'd1 << 18) + 64'd59) / 64'd60);
  localparam logic [9:0]  M100S   = 10'(((64'd1 << 16) + 64'd99) / 64'd100);
  localparam logic [11:0] M153    = 12'(((64'd1 << 19) + 64'd152) / 64'd153);
  localparam logic [11:0] M5      = 12'(((64'd1 << 14) + 64'd4) / 64'd5);
  localparam logic [14:0] M100    = 15'(((64'd1 << 21) + 64'd99) / 64'd100);
  localparam logic [14:0] M400    = 15'(((64'd1 << 23) + 64'd399) / 64'd400);

  function automatic logic [4:0] month_len(input logic [3:0] month, input logic leap);
    logic [4:0] len;
    case (month)
      4'd1, 4'd3, 4'd5, 4'd7, 4'd8, 4'd10, 4'd12: len = 5'd31;
      4'd4, 4'd6, 4'd9, 4'd11:                   len = 5'd30;
      4'd2:                                      len = leap ? 5'd29 : 5'd28;
      default:                                   len = 5'd0;
    endcase
    return len;
  endfunction

endpackage

FILE: src/cdut_days.sv
// cdut_days: three-stage front end, date and time to unix seconds (op 0)
// or seconds passed through (op 1), plus range check; depends on cdut_pkg
`timescale 1ns / 1ps

module cdut_days (
  input  logic                                    clk,
  input  logic [cdut_pkg::FRONT_STAGES-1:0]       en,
  input  cdut_pkg::in_word_t                      in_word,
  output logic [37:0]                             t_out,
  output logic                                    err_out
);

  // days before the month, counted from march
  function automatic logic [8:0] mterm(input logic [3:0] mi);
    logic [8:0] v;
    case (mi)
      4'd0:    v = 9'd0;
      4'd1:    v = 9'd31;
      4'd2:    v = 9'd61;
      4'd3:    v = 9'd92;
      4'd4:    v = 9'd122;
      4'd5:    v = 9'd153;
      4'd6:    v = 9'd184;
      4'd7:    v = 9'd214;
      4'd8:    v = 9'd245;
      4'd9:    v = 9'd275;
      4'd10:   v = 9'd306;
      4'd11:   v = 9'd337;
      default: v = 9'd0;
    endcase
    return v;
  endfunction

  logic        early;
  logic [13:0] yp;
  logic [3:0]  mi;
  logic [28:0] py100;
  logic [28:0] py400;
  logic        bad;

  logic        f1_op_r;
  logic [37:0] f1_t_r;
  logic [4:0]  f1_hh_r;
  logic [5:0]  f1_mm_r;
  logic [5:0]  f1_ss_r;
  logic [4:0]  f1_day_r;
  logic        f1_bad_r;
  logic [21:0] f1_y365_r;
  logic [11:0] f1_y4_r;
  logic [6:0]  f1_y100_r;
  logic [4:0]  f1_y400_r;
  logic [8:0]  f1_mterm_r;

  logic [23:0] days_nxt;
  logic        f2_op_r;
  logic [37:0] f2_t_r;
  logic [4:0]  f2_hh_r;
  logic [5:0]  f2_mm_r;
  logic [5:0]  f2_ss_r;
  logic        f2_bad_r;
  logic [23:0] f2_days_r;

  logic signed [41:0] dsec;
  logic [16:0]        tod;
  logic signed [41:0] total;
  logic [37:0]        t_nxt;
  logic               err_nxt;
  logic [37:0]        t_r;
  logic               err_r;

  // stage 1: march-based year, divisions of the year
  always_comb begin
    early = (in_word.in_month <= 4'd2);
    yp    = early ? in_word.in_year - 14'd1 : in_word.in_year;
    mi    = early ? in_word.in_month + 4'd9 : in_word.in_month - 4'd3;
    py100 = 29'(yp) * 29'(cdut_pkg::M100);
    py400 = 29'(yp) * 29'(cdut_pkg::M400);
    bad   = (in_word.in_month == 4'd0) || (in_word.in_month > 4'd12) ||
            (in_word.in_year < 14'd1970) || (in_word.in_year > 14'd9999);
  end

  always_ff @(posedge clk) begin
    if (en[0]) begin
      f1_op_r    <= in_word.op;
      f1_t_r     <= in_word.in_unix_seconds;
      f1_hh_r    <= in_word.in_hour;
      f1_mm_r    <= in_word.in_minute;
      f1_ss_r    <= in_word.in_second;
      f1_day_r   <= in_word.in_day;
      f1_bad_r   <= bad;
      f1_y365_r  <= 22'(yp) * 22'd365;
      f1_y4_r    <= yp[13:2];
      f1_y100_r  <= py100[27:21];
      f1_y400_r  <= py400[27:23];
      f1_mterm_r <= mterm(mi);
    end
  end

  // stage 2: day number relative to the epoch, may go slightly negative
  always_comb begin
    days_nxt = 24'(f1_y365_r) + 24'(f1_y4_r) - 24'(f1_y100_r) + 24'(f1_y400_r)
             + 24'(f1_mterm_r) + 24'(f1_day_r) - 24'd1 - 24'(cdut_pkg::EPOCH_SHIFT);
  end

  always_ff @(posedge clk) begin
    if (en[1]) begin
      f2_op_r   <= f1_op_r;
      f2_t_r    <= f1_t_r;
      f2_hh_r   <= f1_hh_r;
      f2_mm_r   <= f1_mm_r;
      f2_ss_r   <= f1_ss_r;
      f2_bad_r  <= f1_bad_r;
      f2_days_r <= days_nxt;
    end
  end

  // stage 3: seconds and range check, select the op
  always_comb begin
    dsec  = $signed({{18{f2_days_r[23]}}, f2_days_r}) * 42'sd86400;
    tod   = 17'(f2_hh_r) * 17'd3600 + 17'(f2_mm_r) * 17'd60 + 17'(f2_ss_r);
    total = dsec + $signed({25'd0, tod});
    if (f2_op_r == cdut_pkg::OP_FROM_UNIX) begin
      t_nxt   = f2_t_r;
      err_nxt = (f2_t_r > cdut_pkg::MAX_UNIX);
    end else begin
      t_nxt   = total[37:0];
      err_nxt = f2_bad_r || total[41] || (total[40:0] > 41'(cdut_pkg::MAX_UNIX));
    end
  end

  always_ff @(posedge clk) begin
    if (en[2]) begin
      t_r   <= t_nxt;
      err_r <= err_nxt;
    end
  end

  assign t_out   = t_r;
  assign err_out = err_r;

endmodule

FILE: src/cdut_split.sv
// cdut_split: ten-stage split of unix seconds into date, time, weekday,
// leap flag and month length; depends on cdut_pkg
`timescale 1ns / 1ps

module cdut_split (
  input  logic                                    clk,
  input  logic [cdut_pkg::SPLIT_STAGES-1:0]       en,
  input  logic [37:0]                             t_in,
  input  logic                                    err_in,
  output cdut_pkg::out_word_t                     out_word
);

  // stage 1
  logic [62:0] p1;
  logic [37:0] s1_t_r;
  logic        s1_err_r;
  logic [21:0] s1_days_r;

  // stage 2
  logic [38:0] dsec;
  logic [21:0] z;
  logic [44:0] pe;
  logic [21:0] wx;
  logic [44:0] pw;
  logic [37:0] s2_t_r;
  logic        s2_err_r;
  logic [16:0] s2_sod_r;
  logic [21:0] s2_z_r;
  logic [4:0]  s2_era_r;
  logic [21:0] s2_wx_r;
  logic [19:0] s2_wq_r;

  // stage 3
  logic [22:0] eoff;
  logic [22:0] doe_w;
  logic [34:0] ph;
  logic [21:0] w7;
  logic [37:0] s3_t_r;
  logic        s3_err_r;
  logic [16:0] s3_sod_r;
  logic [17:0] s3_doe_r;
  logic [4:0]  s3_era_r;
  logic [4:0]  s3_hour_r;
  logic [2:0]  s3_wd_r;

  // stage 4
  logic [36:0] pa;
  logic [36:0] pb;
  logic [36:0] pc;
  logic [16:0] hsec;
  logic [37:0] s4_t_r;
  logic        s4_err_r;
  logic [17:0] s4_doe_r;
  logic [4:0]  s4_era_r;
  logic [4:0]  s4_hour_r;
  logic [6:0]  s4_a_r;
  logic [2:0]  s4_b_r;
  logic        s4_c_r;
  logic [11:0] s4_rem_r;
  logic [2:0]  s4_wd_r;

  // stage 5
  logic [17:0] n;
  logic [36:0] py;
  logic [24:0] pm;
  logic [37:0] s5_t_r;
  logic        s5_err_r;
  logic [17:0] s5_doe_r;
  logic [4:0]  s5_era_r;
  logic [4:0]  s5_hour_r;
  logic [5:0]  s5_minute_r;
  logic [11:0] s5_rem_r;
  logic [8:0]  s5_yoe_r;
  logic [2:0]  s5_wd_r;

  // stage 6
  logic [18:0] pq;
  logic [17:0] ydays;
  logic [17:0] doy_w;
  logic [37:0] s6_t_r;
  logic        s6_err_r;
  logic [4:0]  s6_hour_r;
  logic [5:0]  s6_minute_r;
  logic [5:0]  s6_second_r;
  logic [8:0]  s6_doy_r;
  logic [13:0] s6_year0_r;
  logic [2:0]  s6_wd_r;

  // stage 7
  logic [10:0] x153;
  logic [22:0] pmp;
  logic [37:0] s7_t_r;
  logic        s7_err_r;
  logic [4:0]  s7_hour_r;
  logic [5:0]  s7_minute_r;
  logic [5:0]  s7_second_r;
  logic [8:0]  s7_doy_r;
  logic [3:0]  s7_mp_r;
  logic [13:0] s7_year0_r;
  logic [2:0]  s7_wd_r;

  // stage 8
  logic [10:0] x5;
  logic [22:0] pd;
  logic [3:0]  month;
  logic [37:0] s8_t_r;
  logic        s8_err_r;
  logic [4:0]  s8_hour_r;
  logic [5:0]  s8_minute_r;
  logic [5:0]  s8_second_r;
  logic [4:0]  s8_day_r;
  logic [3:0]  s8_month_r;
  logic [13:0] s8_year_r;
  logic [2:0]  s8_wd_r;

  // stage 9
  logic [28:0] p100;
  logic [28:0] p400;
  logic [37:0] s9_t_r;
  logic        s9_err_r;
  logic [4:0]  s9_hour_r;
  logic [5:0]  s9_minute_r;
  logic [5:0]  s9_second_r;
  logic [4:0]  s9_day_r;
  logic [3:0]  s9_month_r;
  logic [13:0] s9_year_r;
  logic [2:0]  s9_wd_r;
  logic [6:0]  s9_q100_r;
  logic [5:0]  s9_q400_r;

  // stage 10
  logic                leap;
  cdut_pkg::out_word_t word_nxt;
  cdut_pkg::out_word_t word_r;

  // day count: (t >> 7) / 675
  always_comb begin
    p1 = 63'(t_in[37:7]) * 63'(cdut_pkg::M675);
  end

  always_ff @(posedge clk) begin
    if (en[0]) begin
      s1_t_r    <= t_in;
      s1_err_r  <= err_in;
      s1_days_r <= p1[62:41];
    end
  end

  // seconds of day, 400-year era, weekday quotient
  always_comb begin
    dsec = 39'(s1_days_r) * 39'(cdut_pkg::SECS_PER_DAY);
    z    = s1_days_r + cdut_pkg::EPOCH_SHIFT;
    pe   = 45'(z) * 45'(cdut_pkg::M146097);
    wx   = s1_days_r + 22'd4;
    pw   = 45'(wx) * 45'(cdut_pkg::M7);
  end

  always_ff @(posedge clk) begin
    if (en[1]) begin
      s2_t_r   <= s1_t_r;
      s2_err_r <= s1_err_r;
      s2_sod_r <= s1_t_r[16:0] - dsec[16:0];
      s2_z_r   <= z;
      s2_era_r <= pe[44:40];
      s2_wx_r  <= wx;
      s2_wq_r  <= pw[44:25];
    end
  end

  // day of era, hour, weekday
  always_comb begin
    eoff  = 23'(s2_era_r) * 23'd146097;
    doe_w = 23'(s2_z_r) - eoff;
    ph    = 35'(s2_sod_r) * 35'(cdut_pkg::M3600);
    w7    = 22'(s2_wq_r) * 22'd7;
  end

  always_ff @(posedge clk) begin
    if (en[2]) begin
      s3_t_r    <= s2_t_r;
      s3_err_r  <= s2_err_r;
      s3_sod_r  <= s2_sod_r;
      s3_doe_r  <= doe_w[17:0];
      s3_era_r  <= s2_era_r;
      s3_hour_r <= ph[33:29];
      s3_wd_r   <= 3'(s2_wx_r - w7);
    end
  end

  // leap corrections within the era, seconds within the hour
  always_comb begin
    pa   = 37'(s3_doe_r) * 37'(cdut_pkg::M1460);
    pb   = 37'(s3_doe_r) * 37'(cdut_pkg::M36524);
    pc   = 37'(s3_doe_r) * 37'(cdut_pkg::M146096);
    hsec = 17'(s3_hour_r) * 17'd3600;
  end

  always_ff @(posedge clk) begin
    if (en[3]) begin
      s4_t_r    <= s3_t_r;
      s4_err_r  <= s3_err_r;
      s4_doe_r  <= s3_doe_r;
      s4_era_r  <= s3_era_r;
      s4_hour_r <= s3_hour_r;
      s4_a_r    <= pa[35:29];
      s4_b_r    <= pb[36:34];
      s4_c_r    <= pc[36];
      s4_rem_r  <= 12'(s3_sod_r - hsec);
      s4_wd_r   <= s3_wd_r;
    end
  end

  // year of era, minute
  always_comb begin
    n  = s4_doe_r - 18'(s4_a_r) + 18'(s4_b_r) - 18'(s4_c_r);
    py = 37'(n) * 37'(cdut_pkg::M365);
    pm = 25'(s4_rem_r) * 25'(cdut_pkg::M60);
  end

  always_ff @(posedge clk) begin
    if (en[4]) begin
      s5_t_r      <= s4_t_r;
      s5_err_r    <= s4_err_r;
      s5_doe_r    <= s4_doe_r;
      s5_era_r    <= s4_era_r;
      s5_hour_r   <= s4_hour_r;
      s5_minute_r <= pm[23:18];
      s5_rem_r    <= s4_rem_r;
      s5_yoe_r    <= py[35:27];
      s5_wd_r     <= s4_wd_r;
    end
  end

  // day of year (march based), second, base year
  always_comb begin
    pq    = 19'(s5_yoe_r) * 19'(cdut_pkg::M100S);
    ydays = 18'(s5_yoe_r) * 18'd365 + 18'(s5_yoe_r[8:2]) - 18'(pq[18:16]);
    doy_w = s5_doe_r - ydays;
  end

  always_ff @(posedge clk) begin
    if (en[5]) begin
      s6_t_r      <= s5_t_r;
      s6_err_r    <= s5_err_r;
      s6_hour_r   <= s5_hour_r;
      s6_minute_r <= s5_minute_r;
      s6_second_r <= 6'(s5_rem_r - 12'(s5_minute_r) * 12'd60);
      s6_doy_r    <= doy_w[8:0];
      s6_year0_r  <= 14'(s5_yoe_r) + 14'(s5_era_r) * 14'd400;
      s6_wd_r     <= s5_wd_r;
    end
  end

  // month index from march
  always_comb begin
    x153 = 11'(s6_doy_r) * 11'd5 + 11'd2;
    pmp  = 23'(x153) * 23'(cdut_pkg::M153);
  end

  always_ff @(posedge clk) begin
    if (en[6]) begin
      s7_t_r      <= s6_t_r;
      s7_err_r    <= s6_err_r;
      s7_hour_r   <= s6_hour_r;
      s7_minute_r <= s6_minute_r;
      s7_second_r <= s6_second_r;
      s7_doy_r    <= s6_doy_r;
      s7_mp_r     <= pmp[22:19];
      s7_year0_r  <= s6_year0_r;
      s7_wd_r     <= s6_wd_r;
    end
  end

  // day of month, calendar month and year
  always_comb begin
    x5    = 11'(s7_mp_r) * 11'd153 + 11'd2;
    pd    = 23'(x5) * 23'(cdut_pkg::M5);
    month = (s7_mp_r < 4'd10) ? s7_mp_r + 4'd3 : s7_mp_r - 4'd9;
  end

  always_ff @(posedge clk) begin
    if (en[7]) begin
      s8_t_r      <= s7_t_r;
      s8_err_r    <= s7_err_r;
      s8_hour_r   <= s7_hour_r;
      s8_minute_r <= s7_minute_r;
      s8_second_r <= s7_second_r;
      s8_day_r    <= 5'(s7_doy_r - pd[22:14] + 9'd1);
      s8_month_r  <= month;
      s8_year_r   <= s7_year0_r + ((month <= 4'd2) ? 14'd1 : 14'd0);
      s8_wd_r     <= s7_wd_r;
    end
  end

  // century quotients for the leap test
  always_comb begin
    p100 = 29'(s8_year_r) * 29'(cdut_pkg::M100);
    p400 = 29'(s8_year_r) * 29'(cdut_pkg::M400);
  end

  always_ff @(posedge clk) begin
    if (en[8]) begin
      s9_t_r      <= s8_t_r;
      s9_err_r    <= s8_err_r;
      s9_hour_r   <= s8_hour_r;
      s9_minute_r <= s8_minute_r;
      s9_second_r <= s8_second_r;
      s9_day_r    <= s8_day_r;
      s9_month_r  <= s8_month_r;
      s9_year_r   <= s8_year_r;
      s9_wd_r     <= s8_wd_r;
      s9_q100_r   <= p100[27:21];
      s9_q400_r   <= p400[28:23];
    end
  end

  // leap flag, month length, error zeroing
  always_comb begin
    leap = ((s9_year_r[1:0] == 2'd0) && (s9_year_r != 14'(s9_q100_r) * 14'd100)) ||
           (s9_year_r == 14'(s9_q400_r) * 14'd400);
    word_nxt = '0;
    if (s9_err_r) begin
      word_nxt.range_error = 1'b1;
    end else begin
      word_nxt.out_unix_seconds = s9_t_r;
      word_nxt.out_year         = s9_year_r;
      word_nxt.out_month        = s9_month_r;
      word_nxt.out_day          = s9_day_r;
      word_nxt.out_hour         = s9_hour_r;
      word_nxt.out_minute       = s9_minute_r;
      word_nxt.out_second       = s9_second_r;
      word_nxt.weekday          = s9_wd_r;
      word_nxt.leap_flag        = leap;
      word_nxt.month_length     = cdut_pkg::month_len(s9_month_r, leap);
    end
  end

  always_ff @(posedge clk) begin
    if (en[9]) begin
      word_r <= word_nxt;
    end
  end

  assign out_word = word_r;

endmodule

FILE: src/civil_date_unix_time_convert.sv
// civil_date_unix_time_convert: top level, stage valid bits and flow control
// around the cdut_days front end and cdut_split back end; depends on cdut_pkg
`timescale 1ns / 1ps

// converter between unix seconds and a gregorian date and time of day
// input channel: in_valid / in_stall / in_word; a word is taken on a rising
// edge with in_valid high and in_stall low. op 0 turns the date and time
// fields into seconds, op 1 splits in_unix_seconds into date, time and weekday
// output channel: out_valid / out_stall / out_word; every input word gives
// exactly one output word, in order, with leap flag, month length and
// range_error (all other fields zero when range_error is set)
// pipeline: 13 register stages, made of the 3 front stages (date to signed
// seconds) and the 10 split stages
// throughput: one word per cycle, sustained while out_stall stays low
// stall: each stage holds while the one after it is full and stalled, so
// bubbles are squeezed out; in_stall rises only when all 13 stages hold a
// word and out_stall is high, and out_word holds while stalled
// reset: rst_n low clears all stage valid bits; data registers are not reset
module civil_date_unix_time_convert (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  input  cdut_pkg::in_word_t  in_word,
  output logic                out_valid,
  input  logic                out_stall,
  output cdut_pkg::out_word_t out_word
);

  localparam int NSTG = cdut_pkg::FRONT_STAGES + cdut_pkg::SPLIT_STAGES;

  logic [NSTG-1:0] v_r;
  logic [NSTG-1:0] adv;
  logic [37:0]     t_mid;
  logic            err_mid;

  // a stage loads when it is empty or its word moves on
  always_comb begin
    adv[NSTG-1] = !v_r[NSTG-1] || !out_stall;
    for (int i = NSTG - 2; i >= 0; i--) begin
      adv[i] = !v_r[i] || adv[i+1];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else begin
      if (adv[0]) begin
        v_r[0] <= in_valid;
      end
      for (int i = 1; i < NSTG; i++) begin
        if (adv[i]) begin
          v_r[i] <= v_r[i-1];
        end
      end
    end
  end

  assign in_stall  = !adv[0];
  assign out_valid = v_r[NSTG-1];

  // front end: date and time to seconds, range check
  cdut_days u_days (
    .clk     (clk),
    .en      (adv[cdut_pkg::FRONT_STAGES-1:0]),
    .in_word (in_word),
    .t_out   (t_mid),
    .err_out (err_mid)
  );

  // back end: seconds to calendar fields
  cdut_split u_split (
    .clk      (clk),
    .en       (adv[NSTG-1:cdut_pkg::FRONT_STAGES]),
    .t_in     (t_mid),
    .err_in   (err_mid),
    .out_word (out_word)
  );

`ifndef SYNTHESIS
  // input only backs up when the whole pipeline is full and the output stalls
  a_stall_full: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> ((&v_r) && out_stall))
    else $error("input stalled with room in the pipeline");

  // a range error zeroes the seconds, year, leap flag and month length
  a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_word.range_error) |->
      (out_word.out_unix_seconds == 38'd0 && out_word.out_year == 14'd0 &&
       out_word.month_length == 5'd0 && out_word.leap_flag == 1'b0))
    else $error("range error with nonzero fields");

  // a good date has legal month, day within month length, weekday 0 to 6
  a_date_ok: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_word.range_error) |->
      (out_word.out_month >= 4'd1 && out_word.out_month <= 4'd12 &&
       out_word.out_day >= 5'd1 && out_word.out_day <= out_word.month_length &&
       out_word.weekday <= 3'd6))
    else $error("calendar fields out of range");

  // february length follows the leap flag
  a_feb_len: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_word.range_error && out_word.out_month == 4'd2) |->
      (out_word.month_length == (out_word.leap_flag ? 5'd29 : 5'd28)))
    else $error("february length disagrees with leap flag");
`endif

endmodule

FILE: bench/cdut_checker.sv
// cdut_checker: watches both channels of the date / seconds converter,
// predicts every result word and compares; depends on cdut_pkg
`timescale 1ns / 1ps

module cdut_checker (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  input  logic                in_stall,
  input  cdut_pkg::in_word_t  in_word,
  input  logic                out_valid,
  input  logic                out_stall,
  input  cdut_pkg::out_word_t out_word,
  output int                  fail_count,
  output int                  pending
);

  cdut_pkg::out_word_t expected_words[$];

  function automatic bit leap_year(longint y);
    return ((y % 4 == 0) && (y % 100 != 0)) || (y % 400 == 0);
  endfunction

  function automatic logic [4:0] days_in_month(longint y, longint m);
    logic [4:0] n;
    case (m)
      1, 3, 5, 7, 8, 10, 12: n = 5'd31;
      4, 6, 9, 11:           n = 5'd30;
      2:                     n = leap_year(y) ? 5'd29 : 5'd28;
      default:               n = 5'd0;
    endcase
    return n;
  endfunction

  function automatic cdut_pkg::out_word_t split_time(longint t);
    cdut_pkg::out_word_t w;
    longint days, sod, z, era, doe, yoe, doy, mp, dd, mo, yr;
    days = t / 86400;
    sod  = t % 86400;
    z    = days + 719468;
    era  = z / 146097;
    doe  = z - era * 146097;
    yoe  = (doe - doe / 1460 + doe / 36524 - doe / 146096) / 365;
    doy  = doe - (365 * yoe + yoe / 4 - yoe / 100);
    mp   = (5 * doy + 2) / 153;
    dd   = doy - (153 * mp + 2) / 5 + 1;
    mo   = (mp < 10) ? mp + 3 : mp - 9;
    yr   = yoe + era * 400 + ((mo <= 2) ? 1 : 0);
    w = '0;
    w.out_unix_seconds = t[37:0];
    w.out_year   = yr[13:0];
    w.out_month  = mo[3:0];
    w.out_day    = dd[4:0];
    w.out_hour   = 5'(sod / 3600);
    w.out_minute = 6'((sod % 3600) / 60);
    w.out_second = 6'(sod % 60);
    w.weekday    = 3'((days + 4) % 7);
    w.leap_flag  = leap_year(yr);
    w.month_length = days_in_month(yr, mo);
    return w;
  endfunction

  function automatic cdut_pkg::out_word_t convert_word(cdut_pkg::in_word_t iw);
    cdut_pkg::out_word_t err;
    longint y, m, days, total;
    err = '0;
    err.range_error = 1'b1;
    if (iw.op == cdut_pkg::OP_FROM_UNIX) begin
      if (longint'(iw.in_unix_seconds) > 64'd253402300799) return err;
      return split_time(longint'(iw.in_unix_seconds));
    end
    y = iw.in_year;
    m = iw.in_month;
    if (m < 1 || m > 12 || y < 1970 || y > 9999) return err;
    if (m <= 2) begin
      y = y - 1;
      m = m + 12;
    end
    days = 365 * y + y / 4 - y / 100 + y / 400 + (153 * (m - 3) + 2) / 5
         + (longint'(iw.in_day) - 1) - 719468;
    total = days * 86400 + longint'(iw.in_hour) * 3600
          + longint'(iw.in_minute) * 60 + longint'(iw.in_second);
    if (total < 0 || total > 64'd253402300799) return err;
    return split_time(total);
  endfunction

  initial fail_count = 0;
  assign pending = expected_words.size();

  always @(posedge clk) begin
    cdut_pkg::out_word_t exp_w;
    if (rst_n) begin
      if (in_valid && !in_stall) expected_words.push_back(convert_word(in_word));
      if (out_valid && !out_stall) begin
        if (expected_words.size() == 0) begin
          fail_count <= fail_count + 1;
          if (fail_count < 10) $display("unexpected word %h", out_word);
        end else begin
          exp_w = expected_words.pop_front();
          if (exp_w !== out_word) begin
            fail_count <= fail_count + 1;
            if (fail_count < 10)
              $display("mismatch: expected %p actual %p", exp_w, out_word);
          end
        end
      end
    end
  end
endmodule

FILE: bench/tb_civil_date_unix_time_convert.sv
// tb_civil_date_unix_time_convert: stimulus and verdict for the converter;
// depends on cdut_pkg, cdut_checker and the block itself
`timescale 1ns / 1ps

module tb_civil_date_unix_time_convert;

  logic                clk = 1'b0;
  logic                rst_n = 1'b0;
  logic                in_valid = 1'b0;
  logic                in_stall;
  cdut_pkg::in_word_t  in_word = '0;
  logic                out_valid;
  logic                out_stall = 1'b0;
  cdut_pkg::out_word_t out_word;
  int                  fail_count;
  int                  pending;
  bit                  hold_long = 1'b0;   // set by the sender to request a long receiver stall
  bit                  stim_done = 1'b0;

  always #1 clk = ~clk;

  civil_date_unix_time_convert uut (
    .clk(clk), .rst_n(rst_n), .in_valid(in_valid), .in_stall(in_stall),
    .in_word(in_word), .out_valid(out_valid), .out_stall(out_stall),
    .out_word(out_word)
  );

  cdut_checker chk (
    .clk(clk), .rst_n(rst_n), .in_valid(in_valid), .in_stall(in_stall),
    .in_word(in_word), .out_valid(out_valid), .out_stall(out_stall),
    .out_word(out_word), .fail_count(fail_count), .pending(pending)
  );

  // date request word, unused seconds field filled with noise
  function automatic cdut_pkg::in_word_t date_word(int y, int m, int d, int hh, int mi, int s);
    cdut_pkg::in_word_t w;
    w.op = cdut_pkg::OP_TO_UNIX;
    w.in_unix_seconds = 38'({$urandom, $urandom});
    w.in_year = 14'(y);
    w.in_month = 4'(m);
    w.in_day = 5'(d);
    w.in_hour = 5'(hh);
    w.in_minute = 6'(mi);
    w.in_second = 6'(s);
    return w;
  endfunction

  // seconds request word, unused date fields are noise
  function automatic cdut_pkg::in_word_t secs_word(longint t);
    cdut_pkg::in_word_t w;
    w = cdut_pkg::in_word_t'({$urandom, $urandom, $urandom});
    w.op = cdut_pkg::OP_FROM_UNIX;
    w.in_unix_seconds = t[37:0];
    return w;
  endfunction

  function automatic cdut_pkg::in_word_t random_word();
    cdut_pkg::in_word_t w;
    int pick;
    longint t;
    pick = $urandom_range(0, 99);
    if (pick < 40) begin
      // mostly well-formed dates, with day and time overflow now and then
      w = date_word($urandom_range(1970, 9999), $urandom_range(1, 12),
                    $urandom_range(1, 28), $urandom_range(0, 23),
                    $urandom_range(0, 59), $urandom_range(0, 59));
      if ($urandom_range(0, 3) == 0) begin
        w.in_day = 5'($urandom);
        w.in_hour = 5'($urandom);
        w.in_minute = 6'($urandom);
        w.in_second = 6'($urandom);
      end
    end else if (pick < 80) begin
      t = {$urandom, $urandom} % 64'd253402300800;
      w = secs_word(t);
    end else if (pick < 90) begin
      w = cdut_pkg::in_word_t'({$urandom, $urandom, $urandom});   // raw noise, any field
    end else begin
      // near the top and bottom of the range
      if ($urandom_range(0, 1)) w = secs_word(64'd253402300799 - $urandom_range(0, 200000));
      else w = secs_word($urandom_range(0, 200000));
    end
    return w;
  endfunction

  cdut_pkg::in_word_t directed[$];

  // drive one word and wait for its acceptance
  task automatic send_word(cdut_pkg::in_word_t w);
    in_valid <= 1'b1;
    in_word <= w;
    @(posedge clk);
    while (in_stall) @(posedge clk);
  endtask

  // a zero-length gap leaves valid high for the next word
  task automatic idle_gap(int n);
    if (n > 0) begin
      in_valid <= 1'b0;
      repeat (n) @(posedge clk);
    end
  endtask

  // receiver: random stall pattern plus a long hold-off on request
  initial begin
    int hold;
    @(posedge rst_n);
    forever begin
      @(posedge clk);
      if (hold_long) begin
        out_stall <= 1'b1;
        for (hold = 0; hold < 60; hold++) @(posedge clk);
        hold_long = 1'b0;
      end
      case ($urandom_range(0, 3))
        0:       out_stall <= ($urandom_range(0, 1) == 1);
        1:       out_stall <= 1'b0;
        default: out_stall <= ($urandom_range(0, 5) == 0);
      endcase
    end
  end

  initial begin
    int burst, i, sent;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    // directed: field extremes and each special case
    directed.push_back(date_word(1970, 1, 1, 0, 0, 0));
    directed.push_back(date_word(9999, 12, 31, 23, 59, 59));
    directed.push_back(date_word(2000, 2, 29, 12, 0, 0));
    directed.push_back(date_word(1900 + 100, 3, 0, 0, 0, 0));      // day zero
    directed.push_back(date_word(2023, 12, 31, 24, 0, 0));         // hour rolls over
    directed.push_back(date_word(2023, 6, 31, 31, 63, 63));        // day and time fields overflow
    directed.push_back(date_word(2024, 0, 1, 0, 0, 0));            // bad month
    directed.push_back(date_word(2024, 13, 1, 0, 0, 0));
    directed.push_back(date_word(2024, 15, 31, 31, 63, 63));
    directed.push_back(date_word(1969, 12, 31, 23, 59, 59));       // bad year
    directed.push_back(date_word(10000, 1, 1, 0, 0, 0));
    directed.push_back(date_word(16383, 1, 1, 0, 0, 0));
    directed.push_back(date_word(0, 1, 1, 0, 0, 0));
    directed.push_back(date_word(1970, 1, 0, 0, 0, 0));            // before the epoch
    directed.push_back(date_word(9999, 12, 31, 23, 59, 60));       // past the end
    directed.push_back(date_word(9999, 12, 31, 31, 63, 63));
    directed.push_back(date_word(2100, 2, 28, 0, 0, 0));
    directed.push_back(secs_word(0));
    directed.push_back(secs_word(64'd253402300799));
    directed.push_back(secs_word(64'd253402300800));               // seconds too large
    directed.push_back(secs_word(64'h3f_ffff_ffff));
    directed.push_back(secs_word(64'd951782400));                  // 2000-02-29
    directed.push_back(secs_word(64'd4107542400));                 // 2100-03-01
    foreach (directed[k]) send_word(directed[k]);
    idle_gap(1);

    sent = 0;
    while (sent < 900) begin
      burst = $urandom_range(1, 40);
      for (i = 0; i < burst; i++) send_word(random_word());
      sent += burst;
      if (sent > 200 && sent - burst <= 200) begin
        // fill the pipe against a long receiver stall
        hold_long = 1'b1;
        for (i = 0; i < 40; i++) send_word(random_word());
        sent += 40;
      end
      if (sent > 500 && sent - burst <= 500) begin
        // drain completely before going on
        in_valid <= 1'b0;
        @(posedge clk);
        while (pending != 0) @(posedge clk);
      end
      idle_gap($urandom_range(0, 1) ? 0 : $urandom_range(1, 12));
    end
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    if (fail_count == 0) $display("SUCCESS");
    else $display("FAILURE");
    $finish;
  end

  initial begin
    #400000;
    $display("FAILURE");
    $finish;
  end
endmodule

FILE: filelist.f
src/cdut_pkg.sv
src/cdut_days.sv
src/cdut_split.sv
src/civil_date_unix_time_convert.sv
bench/cdut_checker.sv
bench/tb_civil_date_unix_time_convert.sv
